// ----- rtl/mppd_pkg.sv -----
package mppd_pkg;

   localparam int POS_W      = 24;
   localparam int SEP_W      = POS_W + 1;
   localparam int AXIS_W     = 18;
   localparam int RATIO_W    = 20;
   localparam int OPW        = POS_W + 6;
   localparam int PROD_W     = 2 * OPW;
   localparam int PERP_W     = 2 * OPW;
   localparam int RP_W       = RATIO_W + OPW;
   localparam int RPL_W      = 24;
   localparam int RPH_W      = RP_W - RPL_W;
   localparam int ACC_W      = 2 * RP_W + 2;
   localparam int FRAC_W     = 16;
   localparam int BEST_W     = 64;
   localparam int DIST_W     = 24;
   localparam int SQ_W       = 2 * DIST_W;
   localparam int BIT_W      = 5;
   localparam int STEP_W     = 5;
   localparam int NSTEPS     = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = ((3 * POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((DIST_W + 7) / 8) * 8;

   localparam logic [POS_W-1:0]   START_RST    = '0;
   localparam logic [AXIS_W-1:0]  AXIS_X_RST   = '0;
   localparam logic [AXIS_W-1:0]  AXIS_Y_RST   = '0;
   localparam logic [AXIS_W-1:0]  AXIS_Z_RST   = AXIS_W'(65536);
   localparam logic [RATIO_W-1:0] RATIO_RST    = RATIO_W'(58982);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_START_X   = 3'd0,
      REG_START_Y   = 3'd1,
      REG_START_Z   = 3'd2,
      REG_AXIS_X    = 3'd3,
      REG_AXIS_Y    = 3'd4,
      REG_AXIS_Z    = 3'd5,
      REG_MAX_RATIO = 3'd6
   } reg_idx_type;

   typedef enum logic [3:0] {
      A_NONE, A_SX, A_SY, A_SZ, A_CX, A_CY, A_CZ, A_P, A_RPH, A_RPL
   } a_sel_type;

   typedef enum logic [3:0] {
      B_NONE, B_AX, B_AY, B_AZ, B_CX, B_CY, B_CZ, B_RATIO, B_RPH, B_RPL
   } b_sel_type;

   typedef enum logic [2:0] {
      ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_ADD24, ACC_ADD48
   } acc_op_type;

   typedef enum logic [2:0] {
      ST_NONE, ST_CX, ST_CY, ST_CZ, ST_P, ST_PERP, ST_RP, ST_UPD
   } store_type;

   typedef struct packed {
      a_sel_type  a;
      b_sel_type  b;
      acc_op_type op;
      store_type  st;
   } step_type;

   typedef struct packed {
      logic             load_hit;
      step_type         step;
      logic             sqrt_clr;
      logic             sqrt_step;
      logic [BIT_W-1:0] bit_idx;
      logic             out_load;
   } dp_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE, S_MAC, S_FIN, S_SQRT, S_OUT
   } state_type;

   localparam step_type STEP_NOP = '{a: A_NONE, b: B_NONE, op: ACC_NOP, st: ST_NONE};

   // multiply schedule: op and store act in the cycle after the multiply
   function automatic step_type step_cmd(input logic [STEP_W-1:0] k);
      step_type s;
      s = STEP_NOP;
      case (k)
         5'd0:  s = '{a: A_SZ,  b: B_AY,    op: ACC_LOAD,  st: ST_NONE};
         5'd1:  s = '{a: A_SY,  b: B_AZ,    op: ACC_SUB,   st: ST_NONE};
         5'd2:  s = '{a: A_SX,  b: B_AZ,    op: ACC_LOAD,  st: ST_CX};
         5'd3:  s = '{a: A_SZ,  b: B_AX,    op: ACC_SUB,   st: ST_NONE};
         5'd4:  s = '{a: A_SY,  b: B_AX,    op: ACC_LOAD,  st: ST_CY};
         5'd5:  s = '{a: A_SX,  b: B_AY,    op: ACC_SUB,   st: ST_NONE};
         5'd6:  s = '{a: A_SX,  b: B_AX,    op: ACC_LOAD,  st: ST_CZ};
         5'd7:  s = '{a: A_SY,  b: B_AY,    op: ACC_ADD,   st: ST_NONE};
         5'd8:  s = '{a: A_SZ,  b: B_AZ,    op: ACC_ADD,   st: ST_NONE};
         5'd9:  s = '{a: A_CX,  b: B_CX,    op: ACC_LOAD,  st: ST_P};
         5'd10: s = '{a: A_CY,  b: B_CY,    op: ACC_ADD,   st: ST_NONE};
         5'd11: s = '{a: A_CZ,  b: B_CZ,    op: ACC_ADD,   st: ST_NONE};
         5'd12: s = '{a: A_P,   b: B_RATIO, op: ACC_LOAD,  st: ST_PERP};
         5'd13: s = '{a: A_NONE, b: B_NONE, op: ACC_NOP,   st: ST_RP};
         // rp lands in its register at the end of this cycle
         5'd14: s = '{a: A_NONE, b: B_NONE, op: ACC_NOP,   st: ST_NONE};
         5'd15: s = '{a: A_RPL, b: B_RPL,   op: ACC_LOAD,  st: ST_NONE};
         5'd16: s = '{a: A_RPH, b: B_RPL,   op: ACC_ADD24, st: ST_NONE};
         5'd17: s = '{a: A_RPH, b: B_RPL,   op: ACC_ADD24, st: ST_NONE};
         5'd18: s = '{a: A_RPH, b: B_RPH,   op: ACC_ADD48, st: ST_NONE};
         5'd19: s = '{a: A_NONE, b: B_NONE, op: ACC_NOP,   st: ST_UPD};
         default: s = STEP_NOP;
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/mppd_datapath.sv -----
module mppd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mppd_pkg::REQ_DATA_W-1:0]   hit_data,
   input  logic                              csr_we,
   input  logic [mppd_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [mppd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  mppd_pkg::dp_cmd_type              cmd,
   output logic [mppd_pkg::DIST_W-1:0]       min_distance,
   output logic                              none_found
);
   import mppd_pkg::*;

   logic signed [POS_W-1:0]   start_x_ff, start_y_ff, start_z_ff;
   logic signed [AXIS_W-1:0]  axis_x_ff, axis_y_ff, axis_z_ff;
   logic [RATIO_W-1:0]        ratio_ff;
   logic signed [SEP_W-1:0]   sx_ff, sy_ff, sz_ff;
   logic signed [OPW-1:0]     cx_ff, cy_ff, cz_ff, p_ff;
   logic [PERP_W-1:0]         perp_ff;
   logic [RP_W-1:0]           rp_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   acc_op_type                op_ff;
   store_type                 st_ff;
   logic [BEST_W-1:0]         best_ff;
   logic                      any_ff;
   logic [DIST_W-1:0]         root_ff;
   logic [DIST_W-1:0]         min_ff;
   logic                      none_ff;

   logic signed [POS_W-1:0]   hx, hy, hz;
   logic signed [OPW-1:0]     opa, opb;
   logic signed [ACC_W-1:0]   prod_ext;
   logic [ACC_W-1:0]          lhs;
   logic                      p_pos, p_zero, accept;
   logic [PERP_W+BEST_W-1:0]  perp_big;
   logic [BEST_W-1:0]         d2;
   logic [DIST_W-1:0]         cand;
   logic [SQ_W-1:0]           cand_sq;

   assign hx = hit_data[POS_W-1:0];
   assign hy = hit_data[2*POS_W-1:POS_W];
   assign hz = hit_data[3*POS_W-1:2*POS_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= START_RST;
         start_y_ff <= START_RST;
         start_z_ff <= START_RST;
         axis_x_ff  <= AXIS_X_RST;
         axis_y_ff  <= AXIS_Y_RST;
         axis_z_ff  <= AXIS_Z_RST;
         ratio_ff   <= RATIO_RST;
      end else if (csr_we) begin
         case (csr_idx)
            REG_START_X:   start_x_ff <= csr_wdata[POS_W-1:0];
            REG_START_Y:   start_y_ff <= csr_wdata[POS_W-1:0];
            REG_START_Z:   start_z_ff <= csr_wdata[POS_W-1:0];
            REG_AXIS_X:    axis_x_ff  <= csr_wdata[AXIS_W-1:0];
            REG_AXIS_Y:    axis_y_ff  <= csr_wdata[AXIS_W-1:0];
            REG_AXIS_Z:    axis_z_ff  <= csr_wdata[AXIS_W-1:0];
            REG_MAX_RATIO: ratio_ff   <= csr_wdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_hit) begin
         sx_ff <= SEP_W'(hx) - SEP_W'(start_x_ff);
         sy_ff <= SEP_W'(hy) - SEP_W'(start_y_ff);
         sz_ff <= SEP_W'(hz) - SEP_W'(start_z_ff);
      end
   end

   always_comb begin
      case (cmd.step.a)
         A_SX:    opa = OPW'(sx_ff);
         A_SY:    opa = OPW'(sy_ff);
         A_SZ:    opa = OPW'(sz_ff);
         A_CX:    opa = cx_ff;
         A_CY:    opa = cy_ff;
         A_CZ:    opa = cz_ff;
         A_P:     opa = p_ff;
         A_RPH:   opa = {{(OPW-RPH_W){1'b0}}, rp_ff[RP_W-1:RPL_W]};
         A_RPL:   opa = {{(OPW-RPL_W){1'b0}}, rp_ff[RPL_W-1:0]};
         default: opa = '0;
      endcase
      case (cmd.step.b)
         B_AX:    opb = OPW'(axis_x_ff);
         B_AY:    opb = OPW'(axis_y_ff);
         B_AZ:    opb = OPW'(axis_z_ff);
         B_CX:    opb = cx_ff;
         B_CY:    opb = cy_ff;
         B_CZ:    opb = cz_ff;
         B_RATIO: opb = {{(OPW-RATIO_W){1'b0}}, ratio_ff};
         B_RPH:   opb = {{(OPW-RPH_W){1'b0}}, rp_ff[RP_W-1:RPL_W]};
         B_RPL:   opb = {{(OPW-RPL_W){1'b0}}, rp_ff[RPL_W-1:0]};
         default: opb = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
      if (reset) begin
         op_ff <= ACC_NOP;
         st_ff <= ST_NONE;
      end else begin
         op_ff <= cmd.step.op;
         st_ff <= cmd.step.st;
      end
   end

   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      case (op_ff)
         ACC_LOAD:  acc_in = prod_ext;
         ACC_ADD:   acc_in = acc_ff + prod_ext;
         ACC_SUB:   acc_in = acc_ff - prod_ext;
         ACC_ADD24: acc_in = acc_ff + (prod_ext <<< 24);
         ACC_ADD48: acc_in = acc_ff + (prod_ext <<< 48);
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // ratio test: perp2 * 2^32 against (ratio * p)^2, the latter held in acc
   assign lhs      = ACC_W'({perp_ff, 32'b0});
   assign p_zero   = (p_ff == '0);
   assign p_pos    = !p_ff[OPW-1] && !p_zero;
   assign accept   = !p_zero && !(p_pos && (lhs > acc_ff));
   assign perp_big = (PERP_W+BEST_W)'(perp_ff);
   assign d2       = (|(perp_big >> BEST_W)) ? '1 : perp_big[BEST_W-1:0];

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_CX:   cx_ff   <= acc_ff[OPW+FRAC_W-1:FRAC_W];
         ST_CY:   cy_ff   <= acc_ff[OPW+FRAC_W-1:FRAC_W];
         ST_CZ:   cz_ff   <= acc_ff[OPW+FRAC_W-1:FRAC_W];
         ST_P:    p_ff    <= acc_ff[OPW+FRAC_W-1:FRAC_W];
         ST_PERP: perp_ff <= acc_ff[PERP_W-1:0];
         ST_RP:   rp_ff   <= acc_ff[RP_W-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '1;
         any_ff  <= 1'b0;
      end else if (cmd.out_load) begin
         best_ff <= '1;
         any_ff  <= 1'b0;
      end else if (st_ff == ST_UPD && accept) begin
         if (d2 < best_ff) begin
            best_ff <= d2;
         end
         any_ff <= 1'b1;
      end
   end

   // square root, one result bit a cycle from the top
   assign cand    = root_ff | (DIST_W'(1) << cmd.bit_idx);
   assign cand_sq = cand * cand;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_clr) begin
         root_ff <= '0;
      end else if (cmd.sqrt_step && (BEST_W'(cand_sq) <= best_ff)) begin
         root_ff <= cand;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (!any_ff) begin
            min_ff <= '0;
         end else if (|best_ff[BEST_W-1:SQ_W]) begin
            min_ff <= '1;
         end else begin
            min_ff <= root_ff;
         end
         none_ff <= !any_ff;
      end
   end

   assign min_distance = min_ff;
   assign none_found   = none_ff;

endmodule

// ----- rtl/mppd_ctrl.sv -----
module mppd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output mppd_pkg::dp_cmd_type  cmd
);
   import mppd_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      last_in  = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_MAC;
               step_in  = '0;
               last_in  = req_tlast;
            end
         end
         S_MAC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(NSTEPS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            bit_in   = BIT_W'(DIST_W - 1);
            state_in = last_ff ? S_SQRT : S_IDLE;
         end
         S_SQRT: begin
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      cmd           = '0;
      cmd.step      = STEP_NOP;
      cmd.bit_idx   = bit_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_hit = req_tvalid;
         end
         S_MAC:  cmd.step      = step_cmd(step_ff);
         S_FIN:  cmd.sqrt_clr  = last_ff;
         S_SQRT: cmd.sqrt_step = 1'b1;
         S_OUT:  cmd.out_load  = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      bit_ff  <= bit_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/min_perpendicular_projection_distance_unit.sv -----
// Takes the hits of one cluster and keeps the smallest squared perpendicular
// distance from the configured line among the hits that pass the ratio test;
// on the hit flagged tlast it returns floor(sqrt(min)) saturated to 24 bits,
// with tuser set when no hit passed. One item at a time: each hit is accepted,
// runs the 20 steps of the shared 30x30 multiply-accumulate unit and ends with
// the update of the minimum, and the last hit of a cluster then runs the
// bit-serial square root and the result load, which waits until the previous
// result has been taken. Registers may be written only while the block is idle; csr_ready is always high.
module min_perpendicular_projection_distance_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mppd_pkg::REQ_DATA_W-1:0]   req_tdata,  // hit_x, hit_y, hit_z
   input  logic                              req_tlast,  // last_hit
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mppd_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // min_distance
   output logic                              rsp_tuser,  // none_found
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mppd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mppd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mppd_pkg::*;

   dp_cmd_type        cmd;
   logic [DIST_W-1:0] min_distance;

   assign csr_ready = 1'b1;

   mppd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mppd_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .hit_data     (req_tdata),
      .csr_we       (csr_valid),
      .csr_idx      (csr_index),
      .csr_wdata    (csr_data),
      .cmd          (cmd),
      .min_distance (min_distance),
      .none_found   (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(min_distance);

endmodule

// ----- dv/min_perpendicular_projection_distance_unit_tb.sv -----
`timescale 1ns / 100ps

module min_perpendicular_projection_distance_unit_tb;
   import mppd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct {
      logic [23:0] min_dist;
      logic        none;
   } dist_result_type;

   typedef struct {
      logic [23:0] x, y, z;
      logic        last;
      bit          typed;
      logic [23:0] min_dist;
      logic        none;
   } hit_row_type;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tlast;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready, rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // shadow of the line registers and the running minimum
   logic [23:0] line_sx, line_sy, line_sz;
   logic [17:0] dir_x, dir_y, dir_z;
   logic [19:0] ratio_lim;
   logic [63:0] best_d2;
   bit          found_any;

   dist_result_type dist_q[$];
   int snd_idle, rcv_idle;
   int stall_kick;
   int cycles = 0;
   int errors = 0;
   int n_hits = 0;
   int n_dists = 0;
   int n_none = 0;
   int n_accept = 0;

   min_perpendicular_projection_distance_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [23:0] sqrt_sat(input logic [63:0] v);
      logic [23:0] r;
      logic [63:0] c;
      r = '0;
      if (v >= 64'h1_0000_0000_0000) return 24'hFFFFFF;
      for (int b = 23; b >= 0; b--) begin
         c = 64'(r | (24'd1 << b));
         if (c * c <= v) r = c[23:0];
      end
      return r;
   endfunction

   // one hit into the line-distance predictor; a result comes on the last hit
   function automatic bit project_hit(input logic [23:0] hx, hy, hz, input logic last,
                                      output dist_result_type res);
      longint sx, sy, sz, ax, ay, az, cx, cy, cz, par;
      logic [127:0] perp2, rp2;
      logic [63:0] d2;
      bit keep;
      sx = longint'($signed(hx)) - longint'($signed(line_sx));
      sy = longint'($signed(hy)) - longint'($signed(line_sy));
      sz = longint'($signed(hz)) - longint'($signed(line_sz));
      ax = longint'($signed(dir_x));
      ay = longint'($signed(dir_y));
      az = longint'($signed(dir_z));
      cx = (ay * sz - az * sy) >>> 16;
      cy = (az * sx - ax * sz) >>> 16;
      cz = (ax * sy - ay * sx) >>> 16;
      par = (ax * sx + ay * sy + az * sz) >>> 16;
      perp2 = 128'(cx * cx) + 128'(cy * cy) + 128'(cz * cz);
      keep = (par != 0);
      if (par > 0) begin
         rp2 = 128'(longint'(ratio_lim) * par);
         rp2 = rp2 * rp2;
         if ((perp2 << 32) > rp2) keep = 0;
      end
      if (keep) begin
         n_accept++;
         d2 = (perp2[127:64] != 0) ? '1 : perp2[63:0];
         if (d2 < best_d2) best_d2 = d2;
         found_any = 1;
      end
      res.min_dist = found_any ? sqrt_sat(best_d2) : 24'd0;
      res.none = !found_any;
      if (last) begin
         best_d2 = '1;
         found_any = 0;
      end
      return last;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_START_X:   line_sx = val;
         REG_START_Y:   line_sy = val;
         REG_START_Z:   line_sz = val;
         REG_AXIS_X:    dir_x = val[17:0];
         REG_AXIS_Y:    dir_y = val[17:0];
         REG_AXIS_Z:    dir_z = val[17:0];
         REG_MAX_RATIO: ratio_lim = val[19:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_hit(input logic [23:0] hx, hy, hz, input logic last,
                           input bit typed, input dist_result_type typed_res);
      dist_result_type res;
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {hz, hy, hx};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      n_hits++;
      if (project_hit(hx, hy, hz, last, res)) dist_q.push_back(typed ? typed_res : res);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (dist_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [17:0] pick_axis();
      case ($urandom_range(5))
         0: return 18'sd65536;
         1: return -18'sd65536;
         2: return 18'h20000;
         3: return 18'd0;
         default: return 18'($urandom_range(131071) - 65536);
      endcase
   endfunction

   task automatic configure_line();
      csr_write(REG_START_X, 24'($urandom));
      csr_write(REG_START_Y, 24'($urandom_range(4095) - 2048));
      csr_write(REG_START_Z, 24'($urandom));
      csr_write(REG_AXIS_X, {6'($urandom), pick_axis()});
      csr_write(REG_AXIS_Y, {6'($urandom), pick_axis()});
      csr_write(REG_AXIS_Z, {6'($urandom), pick_axis()});
      case ($urandom_range(3))
         0: csr_write(REG_MAX_RATIO, 24'h0);
         1: csr_write(REG_MAX_RATIO, 24'hFFFFF);
         default: csr_write(REG_MAX_RATIO, 24'($urandom));
      endcase
      csr_write(REG_SPARE, 24'($urandom));
   endtask

   task automatic random_clusters(input int n_items);
      int sent, len, t, noise;
      logic [23:0] hx, hy, hz;
      dist_result_type none_res;
      sent = 0;
      none_res = '{min_dist: '0, none: 1'b0};
      while (sent < n_items) begin
         len = $urandom_range(8, 1);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) < 2) begin
               hx = 24'($urandom);
               hy = 24'($urandom);
               hz = 24'($urandom);
            end else begin
               // hits near the line, both ahead of and behind the start point
               t = $urandom_range(200000) - 60000;
               noise = $urandom_range(1 << $urandom_range(14), 0);
               hx = line_sx + 24'((longint'($signed(dir_x)) * t) >>> 16) + 24'(noise);
               hy = line_sy + 24'((longint'($signed(dir_y)) * t) >>> 16)
                    - 24'($urandom_range(noise));
               hz = line_sz + 24'((longint'($signed(dir_z)) * t) >>> 16);
               if ($urandom_range(19) == 0) {hx, hy, hz} = {line_sx, line_sy, line_sz};
            end
            send_hit(hx, hy, hz, k == len - 1, 0, none_res);
         end
         sent += len;
      end
   endtask

   // result side: random ready, long hold-off on request, compare on handshake
   always @(posedge clock) begin
      int stall_left, kick_seen;
      dist_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         kick_seen = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (dist_q.size() == 0) begin
               $error("result with nothing expected: min_distance %0d none_found %0d",
                      rsp_tdata[23:0], rsp_tuser);
               errors++;
            end else begin
               want = dist_q.pop_front();
               n_dists++;
               if (want.none) n_none++;
               if (rsp_tdata[23:0] !== want.min_dist) begin
                  $error("min_distance expected %0d actual %0d", want.min_dist,
                         rsp_tdata[23:0]);
                  errors++;
               end
               if (rsp_tuser !== want.none) begin
                  $error("none_found expected %0d actual %0d", want.none, rsp_tuser);
                  errors++;
               end
            end
         end
         if (kick_seen != stall_kick) begin
            kick_seen = stall_kick;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("min_perpendicular_projection_distance_unit verification failed");
         $finish;
      end
   end

   initial begin
      hit_row_type rows[$];
      dist_result_type tr;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_START_X;
      csr_data = '0;
      stall_kick = 0;
      snd_idle = 27; rcv_idle = 76;
      line_sx = START_RST; line_sy = START_RST; line_sz = START_RST;
      dir_x = AXIS_X_RST; dir_y = AXIS_Y_RST; dir_z = AXIS_Z_RST;
      ratio_lim = RATIO_RST;
      best_d2 = '1;
      found_any = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // straight line along z through the origin, as after reset
      rows = '{
         '{24'd0, 24'd0, 24'd16, 1, 1, 24'd0, 0},
         '{24'd0, 24'd0, 24'd0, 1, 1, 24'd0, 1},         // zero parallel
         '{24'd3, 24'd4, 24'd100, 1, 1, 24'd5, 0},
         '{24'd3, 24'd4, -24'd100, 1, 1, 24'd5, 0},      // behind the start
         '{24'd100, 24'd0, 24'd10, 1, 1, 24'd0, 1},      // fails ratio
         '{24'd30, 24'd40, -24'd5, 0, 0, 24'd0, 0},
         '{24'd0, 24'd0, 24'd0, 0, 0, 24'd0, 0},
         '{24'd3, 24'd4, 24'd100, 0, 0, 24'd0, 0},
         '{24'd7, 24'd1, 24'd9, 1, 1, 24'd5, 0},
         '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0, 0, 24'd0, 0},
         '{24'h800000, 24'h800000, 24'h800000, 1, 0, 24'd0, 0},
         '{24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1, 0, 24'd0, 0},
         '{24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1, 0, 24'd0, 0},
         '{24'hFFFFFF, 24'h000001, 24'h555555, 0, 0, 24'd0, 0},
         '{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1, 0, 24'd0, 0}
      };
      foreach (rows[i]) begin
         tr = '{min_dist: rows[i].min_dist, none: rows[i].none};
         send_hit(rows[i].x, rows[i].y, rows[i].z, rows[i].last, rows[i].typed, tr);
      end
      settle();

      // tilted line with the saturation-prone axis and the ratio extremes
      csr_write(REG_AXIS_X, 24'h20000);
      csr_write(REG_AXIS_Y, 24'h20000);
      csr_write(REG_MAX_RATIO, 24'hFFFFF);
      tr = '{min_dist: '0, none: 1'b0};
      send_hit(24'h7FFFFF, 24'h800000, 24'h123456, 1, 0, tr);
      send_hit(24'h000100, 24'h000200, 24'hFFFF00, 1, 0, tr);
      settle();
      csr_write(REG_MAX_RATIO, 24'h0);
      send_hit(24'h000100, 24'h000200, 24'h000300, 1, 0, tr);
      settle();

      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 3) begin snd_idle = 76; rcv_idle = 27; end
         if (ph == 6) begin
            snd_idle = 0; rcv_idle = 0;
            stall_kick++;
         end
         configure_line();
         random_clusters(105);
         settle();
      end

      $display("%0d hits in, %0d accepted, %0d distances checked (%0d with none found)",
               n_hits, n_accept, n_dists, n_none);
      $display("line settings included unit, zero and out-of-unit axes and ratio extremes");
      if (errors == 0 && dist_q.size() == 0) begin
         $display("min_perpendicular_projection_distance_unit verification clean");
      end else begin
         if (dist_q.size() != 0) $error("%0d expected results never arrived", dist_q.size());
         $display("min_perpendicular_projection_distance_unit verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mppd_pkg.sv
rtl/mppd_datapath.sv
rtl/mppd_ctrl.sv
rtl/min_perpendicular_projection_distance_unit.sv
dv/min_perpendicular_projection_distance_unit_tb.sv
